### hw/rtl/dls_pkg.sv
// Shared types, constants and helpers for the delimiter stripper.
// No dependencies; every other file of the block imports this package.
package dls_pkg;

   localparam int unsigned DLS_MAX_DELIM_LEN = 4;
   // Wide enough for any clamped delimiter length up to eight.
   localparam int unsigned DLS_LEN_W = 4;

   typedef enum logic [1:0] {
      CSR_A_BYTES  = 2'd0,
      CSR_A_LENGTH = 2'd1,
      CSR_B_BYTES  = 2'd2,
      CSR_B_LENGTH = 2'd3
   } dls_csr_index_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_message_end;
   } dls_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       run_last;
      logic       message_end;
   } dls_rsp_type;

   // One stage of the output chain.
   typedef struct packed {
      logic        full;
      dls_rsp_type beat;
   } dls_slot_type;

   typedef struct packed {
      logic [31:0] a_bytes;
      logic [2:0]  a_length;
      logic [31:0] b_bytes;
      logic [2:0]  b_length;
   } dls_cfg_type;

   // Zero length acts as one, anything above the maximum acts as the maximum.
   function automatic logic [DLS_LEN_W-1:0] dls_len(input logic [2:0] raw,
                                                    input logic [DLS_LEN_W-1:0] max_len);
      logic [DLS_LEN_W-1:0] ext;
      ext = DLS_LEN_W'(raw);
      if (raw == 3'd0) begin
         return DLS_LEN_W'(1);
      end else if (ext > max_len) begin
         return max_len;
      end
      return ext;
   endfunction

   // Byte k of a delimiter word; positions past the word read as zero.
   function automatic logic [7:0] dls_byte(input logic [31:0] bytes,
                                           input logic [DLS_LEN_W-1:0] k);
      logic [7:0] sel;
      unique case (k[1:0])
         2'd0: sel = bytes[7:0];
         2'd1: sel = bytes[15:8];
         2'd2: sel = bytes[23:16];
         default: sel = bytes[31:24];
      endcase
      return (k < DLS_LEN_W'(4)) ? sel : 8'h00;
   endfunction

endpackage

### hw/rtl/dls_beat_cell.sv
// One stage of the output chain of the delimiter stripper.
// Depends on dls_pkg for the slot and beat types.
module dls_beat_cell
   import dls_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         pop,
   input  logic         load,
   input  dls_rsp_type  load_beat,
   input  dls_slot_type next,
   output dls_slot_type slot
);

   dls_slot_type slot_ff;
   dls_slot_type slot_in;

   always_comb begin
      priority if (load) begin
         slot_in.full = 1'b1;
         slot_in.beat = load_beat;
      end else if (pop) begin
         slot_in = next;
      end else begin
         slot_in = slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign slot = slot_ff;

endmodule

### hw/rtl/dls_scan.sv
// Candidate tracking for the delimiter stripper: pending byte cells, count,
// delimiter flags, and the burst of beats one input byte produces. Uses dls_pkg.
module dls_scan
   import dls_pkg::*;
#(
   parameter int unsigned MAX_DELIM_LEN = DLS_MAX_DELIM_LEN,
   localparam int unsigned CNT_W = $clog2(MAX_DELIM_LEN),
   localparam int unsigned NW    = $clog2(MAX_DELIM_LEN + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  dls_req_type                     req,
   input  dls_cfg_type                     cfg,
   output dls_rsp_type [MAX_DELIM_LEN-1:0] emit,
   output logic [NW-1:0]                   emit_n
);

   localparam int unsigned PEND_D = MAX_DELIM_LEN - 1;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       flags_ff, flags_in;
   logic [7:0]       pend_ff [PEND_D];

   logic store, emit_data, marker;

   always_comb begin
      logic [DLS_LEN_W-1:0] max_len, cnt_x, len_a, len_b;
      logic                 first_a, first_b, ok_a, ok_b, match_a, match_b;
      logic                 found, match;
      max_len = DLS_LEN_W'(MAX_DELIM_LEN);
      cnt_x   = DLS_LEN_W'(count_ff);
      len_a   = dls_len(cfg.a_length, max_len);
      len_b   = dls_len(cfg.b_length, max_len);
      first_a = (cfg.a_bytes[7:0] == req.in_byte);
      first_b = (cfg.b_bytes[7:0] == req.in_byte);
      ok_a    = flags_ff[0] && (cnt_x < len_a)
                && (dls_byte(cfg.a_bytes, cnt_x) == req.in_byte);
      ok_b    = flags_ff[1] && (cnt_x < len_b)
                && (dls_byte(cfg.b_bytes, cnt_x) == req.in_byte);
      match_a = ok_a && (len_a == cnt_x + DLS_LEN_W'(1));
      match_b = ok_b && (len_b == cnt_x + DLS_LEN_W'(1));
      found   = 1'b0;
      match   = 1'b0;
      flags_in  = flags_ff;
      store     = 1'b0;
      emit_data = 1'b0;

      if (count_ff == '0) begin
         flags_in  = flags_ff | {first_b, first_a};
         emit_data = !(first_a || first_b);
         store     = (first_a || first_b)
                     && !((first_a && len_a == DLS_LEN_W'(1))
                          || (first_b && len_b == DLS_LEN_W'(1)));
      end else begin
         // Check A first; a completed A leaves the B flag untouched.
         flags_in[0] = ok_a;
         if (match_a) begin
            found = 1'b1;
            match = 1'b1;
         end else begin
            flags_in[1] = ok_b;
            found = ok_a || ok_b;
            match = match_b;
         end
         store     = found && !match;
         emit_data = !found;
      end

      count_in = store ? count_ff + CNT_W'(1) : '0;

      // Message end flushes a freshly stored candidate and clears everything.
      marker = 1'b0;
      if (req.in_message_end) begin
         emit_data = emit_data || store;
         marker    = !emit_data;
         count_in  = '0;
         flags_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         flags_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
         flags_ff <= flags_in;
      end
   end

   for (genvar k = 0; k < PEND_D; k++) begin : g_pend
      always_ff @(posedge clock) begin
         if (accept && store && count_ff == CNT_W'(k)) begin
            pend_ff[k] <= req.in_byte;
         end
      end
   end

   // Burst layout: held bytes first, then the current byte at position count.
   for (genvar k = 0; k < MAX_DELIM_LEN; k++) begin : g_emit
      logic [7:0] data_k;
      logic       last_k;
      if (k < PEND_D) begin : g_held
         assign data_k = (CNT_W'(k) < count_ff) ? pend_ff[k] : req.in_byte;
      end else begin : g_cur
         assign data_k = req.in_byte;
      end
      assign last_k              = marker || (CNT_W'(k) == count_ff);
      assign emit[k].out_byte    = marker ? 8'h00 : data_k;
      assign emit[k].out_valid   = !marker;
      assign emit[k].run_last    = last_k;
      assign emit[k].message_end = last_k && req.in_message_end;
   end

   assign emit_n = marker    ? NW'(1) :
                   emit_data ? NW'(count_ff) + NW'(1) : '0;

endmodule

### hw/rtl/delimiter_stripper.sv
// Delimiter stripper top level: register port, candidate scan, output chain.
// Depends on dls_pkg, dls_scan and dls_beat_cell.
//
//   channel   direction  handshake        carries
//   req_      in         valid / stall    dls_req_type  (one raw byte)
//   rsp_      out        valid / stall    dls_rsp_type  (one kept byte or end marker)
//   csr_      in         valid / ready    register index and 32-bit write data
//
// One byte is taken per cycle while req_stall is low; its decision is made in the cycle it is taken.
// Each byte yields zero to MAX_DELIM_LEN beats, loaded at once into a chain of
// 2*MAX_DELIM_LEN stages that drains one beat per cycle at rsp_ while rsp_stall is low.
// req_stall rises while more than MAX_DELIM_LEN beats are queued, so replay
// bursts and a stalled rsp_ throttle the input; otherwise bytes flow one a cycle.
// Reset (synchronous, active high) empties the chain, clears the candidate and
// restores the registers; csr_ready is always high.
module delimiter_stripper
   import dls_pkg::*;
#(
   parameter int unsigned MAX_DELIM_LEN = DLS_MAX_DELIM_LEN
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  dls_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output dls_rsp_type rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int unsigned DEPTH = 2 * MAX_DELIM_LEN;
   localparam int unsigned OW    = $clog2(DEPTH + 1);
   localparam int unsigned CNT_W = $clog2(MAX_DELIM_LEN);
   localparam int unsigned NW    = $clog2(MAX_DELIM_LEN + 1);

   dls_cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.a_bytes  <= '0;
         cfg_ff.a_length <= 3'd1;
         cfg_ff.b_bytes  <= '0;
         cfg_ff.b_length <= 3'd1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_A_BYTES:  cfg_ff.a_bytes  <= csr_data;
            CSR_A_LENGTH: cfg_ff.a_length <= csr_data[2:0];
            CSR_B_BYTES:  cfg_ff.b_bytes  <= csr_data;
            CSR_B_LENGTH: cfg_ff.b_length <= csr_data[2:0];
         endcase
      end
   end

   logic                            accept, pop;
   dls_rsp_type [MAX_DELIM_LEN-1:0] emit;
   logic [NW-1:0]                   emit_n;
   logic [OW-1:0]                   occ_ff, occ_in, base;
   dls_slot_type                    slots [DEPTH+1];

   assign req_stall = (occ_ff > OW'(MAX_DELIM_LEN));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = slots[0].full;
   assign rsp_payload = slots[0].beat;
   assign pop       = rsp_valid && !rsp_stall;

   dls_scan #(
      .MAX_DELIM_LEN(MAX_DELIM_LEN)
   ) u_scan (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .req   (req_payload),
      .cfg   (cfg_ff),
      .emit  (emit),
      .emit_n(emit_n)
   );

   // New beats land right behind whatever is left after this cycle's pop.
   assign base   = occ_ff - OW'(pop);
   assign occ_in = base + (accept ? OW'(emit_n) : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign slots[DEPTH] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_chain
      logic [OW-1:0] off;
      logic          load;
      assign off  = OW'(i) - base;
      assign load = accept && (OW'(i) >= base) && (off < OW'(emit_n));

      dls_beat_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .pop      (pop),
         .load     (load),
         .load_beat(emit[off[CNT_W-1:0]]),
         .next     (slots[i+1]),
         .slot     (slots[i])
      );
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OW'(DEPTH))
      else $error("output chain overfilled");

   a_occ_head: assert property (@(posedge clock) disable iff (reset)
      (occ_ff != '0) == rsp_valid)
      else $error("chain head disagrees with occupancy");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.message_end |-> rsp_payload.run_last)
      else $error("message end beat is not last of its burst");

   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.out_valid |->
         rsp_payload.message_end && rsp_payload.out_byte == 8'h00)
      else $error("end marker malformed");

endmodule

### tb/tb.sv
// Self-checking testbench for delimiter_stripper: strips two delimiters from a byte stream.
// Depends on dls_pkg and the delimiter_stripper RTL; predicts every output beat in-house.
module tb;
   import dls_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SETTLE_CYCLES = 2 * DLS_MAX_DELIM_LEN + 4;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   dls_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   dls_rsp_type rsp_payload;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index   = '0;
   logic [31:0] csr_data    = '0;

   // Predictor copy of the registers and the candidate state
   logic [31:0] cfg_word [2]  = '{32'h0, 32'h0};
   logic [2:0]  cfg_len [2]   = '{3'd1, 3'd1};
   logic [7:0]  pend [DLS_MAX_DELIM_LEN-1];
   int unsigned pend_count    = 0;
   logic [1:0]  cand_flags    = 2'b00;

   dls_rsp_type clean_beats[$];
   int unsigned err_count     = 0;

   int unsigned send_gap_max  = 16;
   int unsigned recv_gap_max  = 16;
   int unsigned hold_cycles   = 0;

   delimiter_stripper dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic int unsigned delim_span(input logic [2:0] raw);
      if (raw == 3'd0) begin
         return 1;
      end
      if (raw > DLS_MAX_DELIM_LEN) begin
         return DLS_MAX_DELIM_LEN;
      end
      return int'(raw);
   endfunction

   function automatic logic [7:0] delim_char(input logic [31:0] word, input int unsigned k);
      if (k >= 4) begin
         return 8'h00;
      end
      return word[8*k +: 8];
   endfunction

   // Work out the beats that one accepted byte produces and queue them.
   task automatic strip_byte(input logic [7:0] b, input logic fin);
      logic [7:0]  kept[$];
      bit          hit;
      bit          drop;
      bit          found;
      bit          matched;
      int unsigned len;
      dls_rsp_type beat;
      hit     = 1'b0;
      drop    = 1'b0;
      found   = 1'b0;
      matched = 1'b0;
      if (pend_count == 0) begin
         // Flags already set stay set when a new candidate starts
         for (int j = 0; j < 2; j++) begin
            if (delim_char(cfg_word[j], 0) == b) begin
               cand_flags[j] = 1'b1;
               hit = 1'b1;
               if (delim_span(cfg_len[j]) == 1) begin
                  drop = 1'b1;
               end
            end
         end
         if (!hit) begin
            kept.push_back(b);
         end else if (!drop) begin
            pend[0]    = b;
            pend_count = 1;
         end
      end else begin
         // Check A then B; the first complete match ends the scan
         for (int j = 0; j < 2 && !matched; j++) begin
            if (cand_flags[j]) begin
               len = delim_span(cfg_len[j]);
               if (pend_count < len && delim_char(cfg_word[j], pend_count) == b) begin
                  found = 1'b1;
                  if (len == pend_count + 1) begin
                     matched = 1'b1;
                  end
               end else begin
                  cand_flags[j] = 1'b0;
               end
            end
         end
         if (matched) begin
            pend_count = 0;
         end else if (found && pend_count < DLS_MAX_DELIM_LEN - 1) begin
            pend[pend_count] = b;
            pend_count++;
         end else begin
            for (int k = 0; k < pend_count; k++) begin
               kept.push_back(pend[k]);
            end
            kept.push_back(b);
            pend_count = 0;
         end
      end
      if (fin) begin
         for (int k = 0; k < pend_count; k++) begin
            kept.push_back(pend[k]);
         end
         pend_count = 0;
         cand_flags = 2'b00;
         if (kept.size() == 0) begin
            beat = '{out_byte: 8'h00, out_valid: 1'b0, run_last: 1'b1, message_end: 1'b1};
            clean_beats.push_back(beat);
            return;
         end
      end
      foreach (kept[k]) begin
         beat.out_byte    = kept[k];
         beat.out_valid   = 1'b1;
         beat.run_last    = (k == kept.size() - 1);
         beat.message_end = beat.run_last & fin;
         clean_beats.push_back(beat);
      end
   endtask

   // Track register writes and input beats, check every output beat.
   always @(posedge clock) begin
      dls_rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_A_BYTES:  cfg_word[0] = csr_data;
               CSR_A_LENGTH: cfg_len[0]  = csr_data[2:0];
               CSR_B_BYTES:  cfg_word[1] = csr_data;
               CSR_B_LENGTH: cfg_len[1]  = csr_data[2:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            strip_byte(req_payload.in_byte, req_payload.in_message_end);
         end
         if (rsp_valid && !rsp_stall) begin
            if (clean_beats.size() == 0) begin
               $error("unexpected beat: out_byte %h out_valid %b run_last %b message_end %b",
                      rsp_payload.out_byte, rsp_payload.out_valid,
                      rsp_payload.run_last, rsp_payload.message_end);
               err_count++;
            end else begin
               want = clean_beats.pop_front();
               if (rsp_payload.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %h, actual %h", want.out_byte,
                         rsp_payload.out_byte);
                  err_count++;
               end
               if (rsp_payload.out_valid !== want.out_valid) begin
                  $error("out_valid: expected %b, actual %b", want.out_valid,
                         rsp_payload.out_valid);
                  err_count++;
               end
               if (rsp_payload.run_last !== want.run_last) begin
                  $error("run_last: expected %b, actual %b", want.run_last,
                         rsp_payload.run_last);
                  err_count++;
               end
               if (rsp_payload.message_end !== want.message_end) begin
                  $error("message_end: expected %b, actual %b", want.message_end,
                         rsp_payload.message_end);
                  err_count++;
               end
            end
         end
      end
   end

   // Output side: random stall before each beat, or one long hold when asked.
   initial begin
      int unsigned wait_n;
      forever begin
         if (hold_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end else begin
            wait_n = (recv_gap_max == 0) ? 0 : $urandom_range(recv_gap_max, 0);
            if (wait_n != 0) begin
               rsp_stall <= 1'b1;
               repeat (wait_n) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid && hold_cycles == 0);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      int unsigned gap;
      gap = (send_gap_max == 0) ? 0 : $urandom_range(send_gap_max, 0);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{in_byte: b, in_message_end: fin};
      do @(posedge clock); while (req_stall);
   endtask

   // Stop offering bytes, wait for every queued beat, then let the block settle.
   // The first wait lets the checker log the last accepted byte before the queue is checked.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (clean_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input dls_csr_index_type idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Length registers get random upper bits; only the low three count.
   task automatic set_delims(input logic [31:0] a_bytes, input logic [2:0] a_len,
                             input logic [31:0] b_bytes, input logic [2:0] b_len);
      logic [31:0] a_word;
      logic [31:0] b_word;
      a_word      = $urandom();
      b_word      = $urandom();
      a_word[2:0] = a_len;
      b_word[2:0] = b_len;
      drain();
      write_reg(CSR_A_BYTES, a_bytes);
      write_reg(CSR_A_LENGTH, a_word);
      write_reg(CSR_B_BYTES, b_bytes);
      write_reg(CSR_B_LENGTH, b_word);
      csr_valid <= 1'b0;
   endtask

   // Both delimiters are a single zero byte out of reset.
   task automatic test_reset_values();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   task automatic test_match_and_replay();
      set_delims(32'h00434241, 3'd3, 32'h00005841, 3'd2);
      send_byte("A", 1'b0);
      send_byte("B", 1'b0);
      send_byte("C", 1'b0);
      // B completes after A drops out
      send_byte("A", 1'b0);
      send_byte("X", 1'b0);
      // miss: replay candidate plus current byte
      send_byte("A", 1'b0);
      send_byte("B", 1'b0);
      send_byte("Z", 1'b0);
      // flush a pending candidate on message end
      send_byte("A", 1'b1);
      // match on the last byte leaves only the end marker
      send_byte("A", 1'b0);
      send_byte("B", 1'b0);
      send_byte("C", 1'b1);
   endtask

   // Length zero acts as one, length seven acts as the maximum.
   task automatic test_length_clamp();
      set_delims(32'h000000FF, 3'd0, 32'h04030201, 3'd7);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(8'h04, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h05, 1'b1);
   endtask

   // A flag left over from a one-byte drop must be cleared as too short.
   task automatic test_stale_flag();
      set_delims(32'h00000051, 3'd1, 32'h00005352, 3'd2);
      send_byte("Q", 1'b0);
      send_byte("R", 1'b0);
      send_byte("S", 1'b0);
      send_byte("R", 1'b0);
      send_byte("X", 1'b1);
   endtask

   // Mostly whole or broken delimiters, the rest near misses and noise.
   task automatic send_stream(input int unsigned n_items);
      logic [7:0]  chunk[$];
      int unsigned sent;
      int unsigned sel;
      int unsigned j;
      int unsigned len;
      int unsigned cut;
      sent = 0;
      while (sent < n_items) begin
         chunk.delete();
         sel = $urandom_range(9, 0);
         j   = $urandom_range(1, 0);
         len = delim_span(cfg_len[j]);
         if (sel < 4) begin
            for (int k = 0; k < len; k++) begin
               chunk.push_back(delim_char(cfg_word[j], k));
            end
         end else if (sel < 6) begin
            cut = $urandom_range(len, 1);
            for (int k = 0; k < cut; k++) begin
               chunk.push_back(delim_char(cfg_word[j], k));
            end
            chunk.push_back(8'($urandom_range(255, 0)));
         end else if (sel < 8) begin
            chunk.push_back(delim_char(cfg_word[$urandom_range(1, 0)], $urandom_range(3, 0)));
         end else begin
            chunk.push_back(8'($urandom_range(255, 0)));
         end
         foreach (chunk[k]) begin
            send_byte(chunk[k], $urandom_range(11, 0) == 0);
            sent++;
         end
      end
   endtask

   task automatic test_random_streams();
      logic [31:0] a_bytes;
      logic [31:0] b_bytes;
      for (int p = 0; p < 6; p++) begin
         a_bytes = $urandom();
         b_bytes = $urandom();
         case (p)
            0: begin
               send_gap_max = 16; recv_gap_max = 16;
               set_delims(a_bytes, 3'd1, b_bytes, 3'd1);
            end
            1: begin
               send_gap_max = 0; recv_gap_max = 0;
               set_delims(a_bytes, 3'd4, b_bytes, 3'd4);
            end
            2: begin
               send_gap_max = 16; recv_gap_max = 0;
               set_delims(a_bytes, 3'd0, b_bytes, 3'd7);
            end
            3: begin
               send_gap_max = 0; recv_gap_max = 16;
               set_delims(a_bytes, 3'($urandom_range(7, 0)), b_bytes,
                          3'($urandom_range(7, 0)));
            end
            4: begin
               // shared prefix so both flags run together
               send_gap_max = 16; recv_gap_max = 16;
               b_bytes[15:0] = a_bytes[15:0];
               set_delims(a_bytes, 3'($urandom_range(4, 2)), b_bytes,
                          3'($urandom_range(4, 2)));
            end
            default: begin
               send_gap_max = 4; recv_gap_max = 8;
               set_delims(32'hFFFFFFFF, 3'($urandom_range(7, 0)), 32'h00000000,
                          3'($urandom_range(7, 0)));
            end
         endcase
         send_stream(65);
      end
      send_gap_max = 16;
      recv_gap_max = 16;
   endtask

   // Hold the output long enough for the block to stall its input.
   task automatic test_backpressure();
      set_delims(32'h00002B2A, 3'd2, 32'h0000002D, 3'd1);
      send_gap_max = 0;
      hold_cycles  = 300;
      for (int i = 0; i < 40; i++) begin
         send_byte(8'($urandom_range(255, 0)), i == 39);
      end
      send_gap_max = 16;
      drain();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_match_and_replay();
      test_length_clamp();
      test_stale_flag();
      test_random_streams();
      test_backpressure();
      drain();
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
